/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/lvsd_pkg.sv */
package lvsd_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int CODE_W     = 8;
   localparam int COEFF_W    = 16;
   localparam int GAIN_W     = 12;
   localparam int STEP_W     = 32;
   localparam int LEVEL_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Datapath widths: accumulator, multiplier B operand, product, gain*127
   localparam int ACC_W      = 26;
   localparam int MULB_W     = 20;
   localparam int PROD_W     = ACC_W + MULB_W;
   localparam int GAIN127_W  = GAIN_W + 7;

   // Register reset values
   localparam logic [COEFF_W-1:0] COEFF_RESET      = '0;
   localparam logic [GAIN_W-1:0]  VOLUME_RESET     = 12'd3276;
   localparam logic [STEP_W-1:0]  PHASE_STEP_RESET = 32'd9739155;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_COEFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd2;

   // Sine table geometry; only a quarter wave is stored
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
   localparam int QTR_W        = SINE_IDX_W - 2;
   localparam int QTR_ENTRIES  = 1 << QTR_W;
   localparam int SINE_MAG_W   = 15;
   localparam int SINE_W       = SINE_MAG_W + 1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   // Micro-operations of the datapath
   typedef enum logic [2:0] {
      UOP_DIFF,    // acc = sample*256 - level
      UOP_MULC,    // prod = acc * coeff
      UOP_UPD,     // level = sat(level + prod>>>16), acc = level
      UOP_MULG,    // prod = acc * gain*127
      UOP_EMIT_F,  // code from filter product
      UOP_PHASE,   // phase += step
      UOP_ROMRD,   // acc = sine(phase) + 32768
      UOP_EMIT_T   // code from tone product
   } uop_type;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_FILTER = 4'd0;
   localparam pc_type PC_TONE   = 4'd5;

   typedef struct packed {
      uop_type op;
      logic    jump_tone;
      pc_type  target;
      logic    last;
   } ucode_type;

   typedef struct packed {
      logic    fire;
      uop_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

   // Microprogram: filter item runs steps 0..4, tone item jumps from 0 to 5..8
   function automatic ucode_type ucode_word(pc_type pc);
      ucode_type w;
      w = '{op: UOP_DIFF, jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
      unique case (pc)
         4'd0: w = '{op: UOP_DIFF,   jump_tone: 1'b1, target: PC_TONE,   last: 1'b0};
         4'd1: w = '{op: UOP_MULC,   jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd2: w = '{op: UOP_UPD,    jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd3: w = '{op: UOP_MULG,   jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd4: w = '{op: UOP_EMIT_F, jump_tone: 1'b0, target: PC_FILTER, last: 1'b1};
         4'd5: w = '{op: UOP_PHASE,  jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd6: w = '{op: UOP_ROMRD,  jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd7: w = '{op: UOP_MULG,   jump_tone: 1'b0, target: PC_FILTER, last: 1'b0};
         4'd8: w = '{op: UOP_EMIT_T, jump_tone: 1'b0, target: PC_FILTER, last: 1'b1};
         default: w = '{op: UOP_EMIT_F, jump_tone: 1'b0, target: PC_FILTER, last: 1'b1};
      endcase
      return w;
   endfunction

   // Sine of r/2^30 quarter turns, Q30 Taylor series to x^15, rounded to Q1.15.
   // Only evaluated at elaboration to build the table.
   function automatic logic [SINE_MAG_W-1:0] quarter_sine(logic [63:0] r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x   = (r * HALF_PI_Q30) >> 30;
      x2  = (x * x) >> 30;
      t   = x;
      sum = $signed(x);
      t   = ((t * x2) >> 30) / 6;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 20;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 42;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 72;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 110;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 156;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 210;
      sum = sum - $signed(t);
      if (sum < 0) begin
         sum = '0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return v[SINE_MAG_W-1:0];
   endfunction

   function automatic logic [QTR_ENTRIES*SINE_MAG_W-1:0] build_qsine();
      logic [QTR_ENTRIES*SINE_MAG_W-1:0] tbl;
      tbl = '0;
      for (int qi = 0; qi < QTR_ENTRIES; qi++) begin
         tbl[qi*SINE_MAG_W +: SINE_MAG_W] = quarter_sine(64'(qi) << (30 - QTR_W));
      end
      return tbl;
   endfunction

   localparam logic [QTR_ENTRIES*SINE_MAG_W-1:0] QSINE_TABLE = build_qsine();
   localparam logic [SINE_MAG_W-1:0]             SINE_PEAK   = quarter_sine(Q30_ONE);

   // Full-wave lookup from the quarter table; odd quadrants mirror, upper half negates
   function automatic logic signed [SINE_W-1:0] sine_entry(logic [SINE_IDX_W-1:0] idx);
      logic [1:0]            quad;
      logic [QTR_W-1:0]      low;
      logic [QTR_W-1:0]      pos;
      logic [SINE_MAG_W-1:0] mag;
      quad = idx[SINE_IDX_W-1 -: 2];
      low  = idx[QTR_W-1:0];
      pos  = quad[0] ? ~low + QTR_W'(1) : low;
      if (quad[0] && low == '0) begin
         mag = SINE_PEAK;
      end else begin
         mag = QSINE_TABLE[pos*SINE_MAG_W +: SINE_MAG_W];
      end
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

/* rtl/core/lvsd_seq.sv */
module lvsd_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     mode,
   input  logic                     out_free,
   output lvsd_pkg::dp_ctrl_type    ctrl,
   output lvsd_pkg::seq_status_type status
);
   import lvsd_pkg::*;

   logic      busy_ff, busy_in;
   pc_type    pc_ff, pc_in;
   logic      mode_ff;
   ucode_type word;
   logic      advance;
   logic      done;

   // Current control word
   always_comb begin
      word = ucode_word(pc_ff);
   end

   // Last step holds until the output register is free
   assign advance = busy_ff && !(word.last && !out_free);
   assign done    = advance && word.last;

   // Step counter with conditional jump on item mode
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (done) begin
         busy_in = 1'b0;
         pc_in   = PC_FILTER;
      end else if (advance) begin
         pc_in = (word.jump_tone && mode_ff) ? word.target : pc_ff + pc_type'(1);
      end
      if (start) begin
         busy_in = 1'b1;
         pc_in   = PC_FILTER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_FILTER;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   // Item mode, held for the jump in the first step
   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff <= mode;
      end
   end

   assign ctrl.fire   = advance;
   assign ctrl.op     = word.op;
   assign status.busy = busy_ff;
   assign status.done = done;

endmodule

/* rtl/core/lvsd_datapath.sv */
module lvsd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [lvsd_pkg::SAMPLE_W-1:0]  sample,
   input  lvsd_pkg::dp_ctrl_type                 ctrl,
   input  logic        [lvsd_pkg::COEFF_W-1:0]   filter_coeff,
   input  logic        [lvsd_pkg::GAIN_W-1:0]    volume_gain,
   input  logic        [lvsd_pkg::STEP_W-1:0]    phase_step,
   output logic        [lvsd_pkg::CODE_W-1:0]    dac_code
);
   import lvsd_pkg::*;

   localparam int UPD_W       = PROD_W - COEFF_W + 1;
   localparam int FILT_SHIFT  = 35;
   localparam int FILT_W      = PROD_W - FILT_SHIFT + 1;
   localparam int TONE_SHIFT  = 27;
   localparam int TONE_W      = 36;
   localparam logic [TONE_W-1:0]        TONE_ROUND = 36'd67108864;
   localparam logic signed [FILT_W-1:0] MIDSCALE   = 12'sd128;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 24'sh7FFFFF;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 24'sh800000;

   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic signed [LEVEL_W-1:0]   level_ff, level_in;
   logic        [STEP_W-1:0]    phase_ff, phase_in;
   logic signed [ACC_W-1:0]     a_ff, a_in;
   logic signed [PROD_W-1:0]    p_ff, p_in;
   logic        [CODE_W-1:0]    code_ff, code_in;

   logic        [GAIN127_W-1:0] gain127;
   logic signed [MULB_W-1:0]    b_op;
   logic signed [ACC_W-1:0]     diff;
   logic signed [UPD_W-1:0]     upd_sum;
   logic signed [LEVEL_W-1:0]   level_sat;
   logic signed [FILT_W-1:0]    filt_sum;
   logic        [CODE_W-1:0]    filt_code;
   logic        [TONE_W-1:0]    tone_sum;
   logic        [CODE_W-1:0]    tone_code;
   logic signed [SINE_W-1:0]    sine_val;

   // Volume times 127 by shift and subtract
   assign gain127 = {volume_gain, 7'b0} - GAIN127_W'(volume_gain);

   // Shared multiplier operand select
   assign b_op = (ctrl.op == UOP_MULC) ? $signed(MULB_W'(filter_coeff))
                                       : $signed(MULB_W'(gain127));

   // Filter difference x*256 - y
   assign diff = ACC_W'($signed({sample_ff, 8'h00})) - ACC_W'(level_ff);

   // Level update with floor shift and 24-bit clamp
   assign upd_sum = UPD_W'(level_ff) + UPD_W'(p_ff >>> COEFF_W);
   always_comb begin
      if (upd_sum[UPD_W-1:LEVEL_W-1] == '0 || upd_sum[UPD_W-1:LEVEL_W-1] == '1) begin
         level_sat = upd_sum[LEVEL_W-1:0];
      end else begin
         level_sat = upd_sum[UPD_W-1] ? LEVEL_MIN : LEVEL_MAX;
      end
   end

   // Filter code: 128 + floor(prod / 2^35), saturated
   assign filt_sum = FILT_W'($signed(p_ff[PROD_W-1:FILT_SHIFT])) + MIDSCALE;
   always_comb begin
      if (filt_sum[FILT_W-1]) begin
         filt_code = '0;
      end else if (filt_sum[FILT_W-2:CODE_W] != '0) begin
         filt_code = '1;
      end else begin
         filt_code = filt_sum[CODE_W-1:0];
      end
   end

   // Tone code: round prod / 2^27, saturated; product is never negative
   assign tone_sum  = TONE_W'(p_ff[TONE_W-2:0]) + TONE_ROUND;
   assign tone_code = tone_sum[TONE_W-1] ? '1 : tone_sum[TONE_SHIFT +: CODE_W];

   // Sine lookup at the top phase bits
   assign sine_val = sine_entry(phase_ff[STEP_W-1 -: SINE_IDX_W]);

   // Micro-op execution
   always_comb begin
      a_in     = a_ff;
      p_in     = p_ff;
      level_in = level_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      if (ctrl.fire) begin
         unique case (ctrl.op)
            UOP_DIFF:   a_in = diff;
            UOP_MULC:   p_in = PROD_W'(a_ff) * PROD_W'(b_op);
            UOP_UPD: begin
               level_in = level_sat;
               a_in     = ACC_W'(level_sat);
            end
            UOP_MULG:   p_in = PROD_W'(a_ff) * PROD_W'(b_op);
            UOP_EMIT_F: code_in = filt_code;
            UOP_PHASE:  phase_in = phase_ff + phase_step;
            UOP_ROMRD:  a_in = ACC_W'({~sine_val[SINE_W-1], sine_val[SINE_W-2:0]});
            UOP_EMIT_T: code_in = tone_code;
            default:    a_in = a_ff;
         endcase
      end
   end

   // Filter and tone state
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         phase_ff <= '0;
      end else begin
         level_ff <= level_in;
         phase_ff <= phase_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample;
      end
      a_ff    <= a_in;
      p_ff    <= p_in;
      code_ff <= code_in;
   end

   assign dac_code = code_ff;

endmodule

/* rtl/core/lowpass_volume_sine_dac_path.sv */
// Channel   Ports                                   Dir   Payload
// req       req_valid req_ready                     in    req_mode, req_sample
// rsp       rsp_valid rsp_ready                     out   rsp_dac_code
// csr       csr_valid csr_ready                     in    csr_index, csr_wdata
//
// One item at a time through a nine-step microprogram driving one shared
// 26x20 multiplier; a filter item runs steps 0-4, a tone item 0 and 5-8.
// The next item is taken on the edge at which the result is stored.
// A full output register holds the last step, which stalls the sequencer.
// Synchronous reset clears level, phase and handshake state, presets CSRs.
`include "assert_macros.svh"

module lowpass_volume_sine_dac_path (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic signed [lvsd_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [lvsd_pkg::CODE_W-1:0]     rsp_dac_code,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [lvsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [lvsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lvsd_pkg::*;

   logic [COEFF_W-1:0] filter_coeff_ff;
   logic [GAIN_W-1:0]  volume_gain_ff;
   logic [STEP_W-1:0]  phase_step_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               out_free;
   dp_ctrl_type        ctrl;
   seq_status_type     status;

   // Configuration writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_coeff_ff <= COEFF_RESET;
         volume_gain_ff  <= VOLUME_RESET;
         phase_step_ff   <= PHASE_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILTER_COEFF: filter_coeff_ff <= csr_wdata[COEFF_W-1:0];
            CSR_VOLUME_GAIN:  volume_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata[STEP_W-1:0];
            default:          phase_step_ff   <= phase_step_ff;
         endcase
      end
   end

   // Input handshake
   assign req_ready = !status.busy || status.done;
   assign accept    = req_valid && req_ready;

   // Output register handshake
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   lvsd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .mode     (req_mode),
      .out_free (out_free),
      .ctrl     (ctrl),
      .status   (status)
   );

   lvsd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .sample       (req_sample),
      .ctrl         (ctrl),
      .filter_coeff (filter_coeff_ff),
      .volume_gain  (volume_gain_ff),
      .phase_step   (phase_step_ff),
      .dac_code     (rsp_dac_code)
   );

   // A result is only stored into a free output register
   `ASSERT_IMP(a_done_free, clock, reset, status.done, out_free)
   // An accepted item keeps the sequencer busy in the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, status.busy)
   // The output only turns valid from a finished item
   `ASSERT_NEXT(a_rsp_source, clock, reset, !rsp_valid_ff && !status.done, !rsp_valid_ff)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import lvsd_pkg::*;

   localparam logic                 MODE_FILTER = 1'b0;
   localparam logic                 MODE_TONE   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                   STALL_LIMIT = 2000;
   localparam int                   PHASES      = 5;
   localparam int                   PHASE_ITEMS = 186;

   // Tracks filter level, tone phase and registers; predicts one code per item
   class dac_code_tracker;
      bit [COEFF_W-1:0]         coeff;
      bit [GAIN_W-1:0]          gain;
      bit [STEP_W-1:0]          step;
      int                       level;
      bit [STEP_W-1:0]          phase;
      int                       sine_tbl[SINE_ENTRIES];
      bit [CODE_W-1:0]          codes_due[$];
      int                       fails;

      function new();
         bit [63:0] t;
         bit [63:0] r;
         int        quad;
         int        s;
         coeff = COEFF_RESET;
         gain  = VOLUME_RESET;
         step  = PHASE_STEP_RESET;
         level = 0;
         phase = '0;
         fails = 0;
         for (int i = 0; i < SINE_ENTRIES; i++) begin
            t    = (64'(i) << 32) / SINE_ENTRIES;
            quad = int'((t >> 30) & 64'd3);
            r    = t & (Q30_ONE - 64'd1);
            if (quad[0]) r = Q30_ONE - r;
            s = quarter_wave(r);
            sine_tbl[i] = quad[1] ? -s : s;
         end
      endfunction

      // Q30 Taylor series to x^15, rounded to Q1.15, clamped to 0..32767
      function int quarter_wave(bit [63:0] r);
         bit [63:0] x;
         bit [63:0] x2;
         bit [63:0] term;
         longint    sum;
         longint    v;
         x    = (r * HALF_PI_Q30) >> 30;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (sum + 16384) >>> 15;
         if (v > 32767) v = 32767;
         return int'(v);
      endfunction

      function void set_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FILTER_COEFF: coeff = data[COEFF_W-1:0];
            CSR_VOLUME_GAIN:  gain  = data[GAIN_W-1:0];
            CSR_PHASE_STEP:   step  = data[STEP_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [CODE_W-1:0] predict_code(bit mode, bit signed [SAMPLE_W-1:0] smp);
         longint d;
         longint y;
         longint num;
         longint s;
         if (mode == MODE_FILTER) begin
            // y += floor((x - y) * alpha), x = sample in Q1.23
            d = longint'(smp) * 256 - longint'(level);
            y = longint'(level) + ((d * longint'(coeff)) >>> 16);
            if (y > 8388607) y = 8388607;
            if (y < -8388608) y = -8388608;
            level = int'(y);
            num = y * longint'(gain) * 127 + (longint'(128) << 35);
            if (num < 0) num = 0;
            num = num >>> 35;
         end else begin
            phase = phase + step;
            s     = longint'(sine_tbl[phase[31 -: SINE_IDX_W]]) + 32768;
            num   = (s * 127 * longint'(gain) + (longint'(1) << 26)) >>> 27;
         end
         if (num > 255) num = 255;
         return num[CODE_W-1:0];
      endfunction

      function void note_item(bit mode, bit signed [SAMPLE_W-1:0] smp);
         codes_due.push_back(predict_code(mode, smp));
      endfunction

      function void check_code(bit [CODE_W-1:0] code);
         bit [CODE_W-1:0] want;
         if (codes_due.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected dac_code %0d", code);
            return;
         end
         want = codes_due.pop_front();
         if (want !== code) begin
            fails++;
            if (fails <= 10) $display("dac_code mismatch: expected %0d got %0d", want, code);
         end
      endfunction

      function int pending();
         return codes_due.size();
      endfunction

      function void check_leftover();
         if (codes_due.size() != 0) begin
            fails++;
            if (fails <= 10) $display("%0d codes never arrived", codes_due.size());
         end
      endfunction
   endclass

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_valid  = 1'b0;
   logic                         req_ready;
   logic                         req_mode   = MODE_FILTER;
   logic signed [SAMPLE_W-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready  = 1'b0;
   logic [CODE_W-1:0]            rsp_dac_code;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index  = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata  = '0;

   dac_code_tracker tracker = new();
   bit              gaps_on = 1'b1;
   int              rsp_hold = 0;
   int              quiet_cycles = 0;

   lowpass_volume_sine_dac_path uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_dac_code (rsp_dac_code),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (gaps_on && $urandom_range(0, 3) == 0) rsp_hold <= gap_len();
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_code(rsp_dac_code);
   end

   // watchdog: cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // returns at the accepting edge with valid still high
   task automatic send_item(input logic mode, input logic signed [SAMPLE_W-1:0] smp);
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_item(mode, smp);
   endtask

   task automatic pause_req(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender holds off until every pending code is back
   task automatic drain();
      pause_req(1);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // register value with random junk above the field width
   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] val,
                                                      input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (width >= CSR_DATA_W) ? '1 : ((32'd1 << width) - 1);
      return ($urandom & ~mask) | (val & mask);
   endfunction

   initial begin
      int tone_pct;
      int gap;
      logic [CSR_DATA_W-1:0] cf;
      logic [CSR_DATA_W-1:0] gn;
      logic [CSR_DATA_W-1:0] st;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, alpha zero keeps the level at zero
      send_item(MODE_FILTER, 16'sh7FFF);
      send_item(MODE_TONE, 16'sh1234);
      send_item(MODE_TONE, 16'sh8000);
      drain();

      // full alpha and volume, sample extremes
      write_reg(CSR_FILTER_COEFF, 32'h0000FFFF);
      write_reg(CSR_VOLUME_GAIN, 32'h00000FFF);
      end_writes();
      send_item(MODE_FILTER, 16'sh8000);
      send_item(MODE_FILTER, 16'sh7FFF);
      send_item(MODE_FILTER, 16'sh0000);
      send_item(MODE_FILTER, -16'sd1);
      send_item(MODE_FILTER, 16'sh7FFF);
      send_item(MODE_TONE, 16'sh7FFF);
      drain();

      // half alpha, zero volume, bits above the width, unused register index
      write_reg(CSR_FILTER_COEFF, 32'hFFFF8000);
      write_reg(CSR_VOLUME_GAIN, 32'hFFFFF000);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      end_writes();
      send_item(MODE_FILTER, 16'sh8000);
      send_item(MODE_TONE, 16'sh0001);
      drain();

      // phase step extremes and quarter-turn steps to hit the peaks
      write_reg(CSR_VOLUME_GAIN, 32'h00000FFF);
      write_reg(CSR_PHASE_STEP, 32'hFFFFFFFF);
      end_writes();
      send_item(MODE_TONE, 16'sh0000);
      send_item(MODE_TONE, 16'sh0000);
      drain();
      write_reg(CSR_PHASE_STEP, 32'h40000000);
      end_writes();
      repeat (4) send_item(MODE_TONE, 16'sh5555);
      drain();
      write_reg(CSR_PHASE_STEP, 32'h80000000);
      end_writes();
      send_item(MODE_TONE, 16'shAAAA);
      send_item(MODE_TONE, 16'shAAAA);
      drain();
      write_reg(CSR_PHASE_STEP, 32'h00000000);
      end_writes();
      send_item(MODE_TONE, 16'sh0000);
      send_item(MODE_FILTER, 16'sh4000);
      drain();

      // random phases, each with its own register settings
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin cf = 32'hFFFF; gn = 32'hFFF; st = $urandom; end
            1: begin cf = 32'h0001; gn = $urandom_range(1, 4095); st = 32'hFFFFFFFF; end
            2: begin cf = $urandom_range(0, 65535); gn = 32'h000; st = 32'h0; end
            3: begin cf = $urandom_range(0, 4095); gn = 32'hFFF; st = $urandom_range(1, 1 << 24); end
            default: begin cf = 32'h8000; gn = $urandom_range(0, 4095); st = $urandom; end
         endcase
         write_reg(CSR_PHASE_STEP, with_junk(st, STEP_W));
         write_reg(CSR_FILTER_COEFF, with_junk(cf, COEFF_W));
         write_reg(CSR_UNUSED, $urandom);
         write_reg(CSR_VOLUME_GAIN, with_junk(gn, GAIN_W));
         end_writes();
         gaps_on  = (p != 2);
         tone_pct = $urandom_range(20, 80);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(($urandom_range(0, 99) < tone_pct) ? MODE_TONE : MODE_FILTER,
                      pick_sample());
            gap = (gaps_on && $urandom_range(0, 9) < 4) ? gap_len() : 0;
            pause_req(gap);
            // sender waits out every outstanding code once mid-run
            if (p == 1 && i == PHASE_ITEMS / 2) drain();
         end
         drain();
      end

      gaps_on = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      tracker.check_leftover();
      if (tracker.fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
